// File: src/vbid_pkg.sv
`default_nettype none

package vbid_pkg;

    // Field widths
    localparam int unsigned VBID_BYTE_W  = 8;
    localparam int unsigned VBID_VALUE_W = 64;
    localparam int unsigned VBID_COUNT_W = 4;

    // Byte layout
    localparam int unsigned VBID_CONT_BIT  = 7;
    localparam int unsigned VBID_SIGN_BIT  = 6;
    localparam int unsigned VBID_DIGIT_W   = 7;
    localparam logic [7:0]  VBID_MASK_U    = 8'h7f;
    localparam logic [7:0]  VBID_MASK_S    = 8'h3f;

    // Shift of a digit: 7 * bytes seen, at most 105
    localparam int unsigned VBID_SHIFT_W   = 7;
    localparam int unsigned VBID_PLACE_W   = VBID_VALUE_W + VBID_DIGIT_W;
    localparam logic [VBID_COUNT_W-1:0] VBID_COUNT_MAX = '1;

    typedef logic [VBID_VALUE_W-1:0] t_value;
    typedef logic [VBID_COUNT_W-1:0] t_count;

endpackage

`default_nettype wire

// File: src/vbid_if.sv
`default_nettype none

// Encoded byte channel
interface vbid_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       signed_value;

    modport source (output valid, output data_byte, output signed_value, input ready);
    modport sink   (input valid, input data_byte, input signed_value, output ready);
endinterface

// Decoded number channel
interface vbid_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_bits;
    logic [3:0]  byte_count;
    logic        overflow;

    modport source (output valid, output value_bits, output byte_count, output overflow,
                    input ready);
    modport sink   (input valid, input value_bits, input byte_count, input overflow,
                    output ready);
endinterface

`default_nettype wire

// File: src/variable_byte_integer_decoder_unit.sv
// Flow: a final byte is accepted into the input register, and its result is then loaded
// into the output register and offered from there.
// Throughput: one byte per cycle; the digit shift and negate sit between the input
// register and the output register, and a waiting result stalls only final bytes.
// Reset: synchronous, active low; clears the valid flags, accumulator, byte count
// and overflow flag. Payload registers are not reset.
`default_nettype none

module variable_byte_integer_decoder_unit
    import vbid_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    vbid_in_if.sink     i_in,
    vbid_out_if.source  o_out
);

    // Input register
    logic                   r_s1_valid;
    logic [VBID_BYTE_W-1:0] r_s1_byte;
    logic                   r_s1_sgn;

    // Number state
    t_value r_acc;
    t_count r_bytes_seen;
    logic   r_ovf_seen;

    // Output register
    logic   r_out_valid;
    t_value r_out_value;
    t_count r_out_count;
    logic   r_out_ovf;

    logic                    s1_final;
    logic                    s1_adv;
    logic                    in_take;
    logic [VBID_BYTE_W-1:0]  digit;
    logic [VBID_SHIFT_W-1:0] shift;
    logic [VBID_PLACE_W-1:0] placed;
    logic                    shift_ok;
    logic                    ovf_new;
    t_value                  acc_sum;
    t_value                  n_value;
    t_count                  n_count;

    // Stage advances unless a final byte meets a held result
    assign s1_final = r_s1_valid && !r_s1_byte[VBID_CONT_BIT];
    assign s1_adv   = r_s1_valid && (!s1_final || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_take  = i_in.valid && i_in.ready;

    // Place the digit at 7 * bytes seen and detect dropped ones
    always_comb begin
        if (s1_final && r_s1_sgn) begin
            digit = r_s1_byte & VBID_MASK_S;
        end else begin
            digit = r_s1_byte & VBID_MASK_U;
        end
        shift    = {r_bytes_seen, 3'b000} - {3'b000, r_bytes_seen};
        shift_ok = shift < VBID_SHIFT_W'(VBID_VALUE_W);
        placed   = shift_ok ? (VBID_PLACE_W'(digit[VBID_DIGIT_W-1:0]) << shift) : '0;
        if (shift_ok) begin
            ovf_new = |placed[VBID_PLACE_W-1:VBID_VALUE_W];
        end else begin
            ovf_new = |digit;
        end
        acc_sum = r_acc | placed[VBID_VALUE_W-1:0];
        if (r_s1_sgn && r_s1_byte[VBID_SIGN_BIT]) begin
            n_value = '0 - acc_sum;
        end else begin
            n_value = acc_sum;
        end
        n_count = (r_bytes_seen == VBID_COUNT_MAX) ? r_bytes_seen
                                                    : r_bytes_seen + t_count'(1);
    end

    // Control and number state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_acc        <= '0;
            r_bytes_seen <= '0;
            r_ovf_seen   <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_adv && s1_final) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_adv) begin
                if (s1_final) begin
                    r_acc        <= '0;
                    r_bytes_seen <= '0;
                    r_ovf_seen   <= 1'b0;
                end else begin
                    r_acc        <= acc_sum;
                    r_bytes_seen <= n_count;
                    r_ovf_seen   <= r_ovf_seen | ovf_new;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte <= i_in.data_byte;
            r_s1_sgn  <= i_in.signed_value;
        end
        if (s1_adv && s1_final) begin
            r_out_value <= n_value;
            r_out_count <= n_count;
            r_out_ovf   <= r_ovf_seen | ovf_new;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.value_bits = r_out_value;
    assign o_out.byte_count = r_out_count;
    assign o_out.overflow   = r_out_ovf;

`ifndef SYNTHESIS
    // A completed number leaves clean state behind
    a_clear_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && s1_final) |=> (r_acc == '0 && r_bytes_seen == '0 && !r_ovf_seen))
        else $error("state not cleared after final byte");

    // A continuation byte counts once, saturating
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && !s1_final && r_bytes_seen != VBID_COUNT_MAX)
        |=> (r_bytes_seen == $past(r_bytes_seen) + t_count'(1)))
        else $error("byte count did not advance");

    // Every held result covers at least one byte
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count != '0))
        else $error("result with zero byte count");

    // Input is refused only while the stage holds a stalled final byte
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (s1_final && r_out_valid && !o_out.ready))
        else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire
